>>> src/pcm2s16_pkg.sv
`default_nettype none
package pcm2s16_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_W = 3;
    localparam int COUNT_W = 4;
    localparam int GAIN_W = 15;
    localparam int PEAK_W = 16;
    localparam int FRAME_W = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DECAY_PROD_W = PEAK_W + GAIN_W;

    // sample format codes; anything else is unsupported
    localparam logic [2:0] FMT_S16 = 3'd0;
    localparam logic [2:0] FMT_S24 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_F32 = 3'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN = 2'd2;

    localparam logic [2:0] RESET_SAMPLE_FORMAT = FMT_S16;
    localparam logic [COUNT_W-1:0] RESET_CHANNEL_COUNT = 4'd2;
    localparam logic [GAIN_W-1:0] RESET_DECAY_GAIN = 15'd23593;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // float32 conversion constants
    localparam logic [14:0] FLOAT_SCALE = 15'd32767;
    localparam logic [15:0] FULL_SCALE = 16'd32767;
    localparam logic [7:0] EXP_ONE = 8'd127;
    localparam logic [7:0] EXP_SPECIAL = 8'd255;
    localparam logic [7:0] EXP_SHIFT_BASE = 8'd150;
    localparam int FLOAT_PROD_W = 39;

    typedef struct packed {
        logic step;
        logic tick;
        logic [CHAN_W-1:0] channel;
        logic [PEAK_W-1:0] mag;
    } meter_in_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_left;
        logic [PEAK_W-1:0] peak_right;
        logic [FRAME_W-1:0] frame_count;
    } stats_t;

endpackage
`default_nettype wire

>>> src/pcm2s16_in_if.sv
`default_nettype none
interface pcm2s16_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic [31:0] raw_sample;
    logic [pcm2s16_pkg::CHAN_W-1:0] channel;
    logic silent;

    modport source (output valid, mode, raw_sample, channel, silent, input ready);
    modport sink (input valid, mode, raw_sample, channel, silent, output ready);
endinterface
`default_nettype wire

>>> src/pcm2s16_out_if.sv
`default_nettype none
interface pcm2s16_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] pcm_sample;
    logic [pcm2s16_pkg::PEAK_W-1:0] peak_left;
    logic [pcm2s16_pkg::PEAK_W-1:0] peak_right;
    logic [pcm2s16_pkg::FRAME_W-1:0] frame_count;

    modport source (output valid, pcm_sample, peak_left, peak_right, frame_count,
                    input ready);
    modport sink (input valid, pcm_sample, peak_left, peak_right, frame_count,
                  output ready);
endinterface
`default_nettype wire

>>> src/pcm2s16_cfg_if.sv
`default_nettype none
interface pcm2s16_cfg_if;
    logic valid;
    logic ready;
    logic [pcm2s16_pkg::CFG_INDEX_W-1:0] index;
    logic [pcm2s16_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/pcm_to_s16_with_peak_meter.sv
`default_nettype none
// Converts interleaved capture samples (s16, s24, s32 or float32, per sample_format) to
// signed 16-bit and keeps a held peak for channels 0 and 1 plus a 40-bit completed-frame
// count; a tick item decays both peaks by decay_gain. One item is accepted per cycle while
// the output is not stalled: the item passes an input register, the conversion and meter
// update run combinationally, and the result sits in an output register that can be
// stalled while the next item is taken. Every item gives exactly one result.
// The configuration port is always ready; write it only while no item is in flight.
module pcm_to_s16_with_peak_meter (
    input wire logic clk,
    input wire logic rst_n,
    pcm2s16_in_if.sink    samples,
    pcm2s16_out_if.source results,
    pcm2s16_cfg_if.sink   cfg
);

    logic [2:0] sample_format_reg;
    logic [pcm2s16_pkg::COUNT_W-1:0] channel_count_reg;
    logic [pcm2s16_pkg::GAIN_W-1:0] decay_gain_reg;

    logic in_valid_reg;
    logic in_mode_reg;
    logic [31:0] in_raw_reg;
    logic [pcm2s16_pkg::CHAN_W-1:0] in_channel_reg;
    logic in_silent_reg;

    logic out_valid_reg;
    logic signed [15:0] out_sample_reg;
    pcm2s16_pkg::stats_t out_stats_reg;

    logic advance;
    logic signed [15:0] conv_sample;
    logic [pcm2s16_pkg::PEAK_W-1:0] conv_mag;
    pcm2s16_pkg::meter_in_t meter_item;
    pcm2s16_pkg::stats_t stats_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg <= pcm2s16_pkg::RESET_SAMPLE_FORMAT;
            channel_count_reg <= pcm2s16_pkg::RESET_CHANNEL_COUNT;
            decay_gain_reg <= pcm2s16_pkg::RESET_DECAY_GAIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pcm2s16_pkg::REG_SAMPLE_FORMAT: sample_format_reg <= cfg.data[2:0];
                pcm2s16_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg.data[pcm2s16_pkg::COUNT_W-1:0];
                pcm2s16_pkg::REG_DECAY_GAIN: decay_gain_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // item leaves the input register when the output register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            in_mode_reg <= samples.mode;
            in_raw_reg <= samples.raw_sample;
            in_channel_reg <= samples.channel;
            in_silent_reg <= samples.silent;
        end
    end

    pcm2s16_cvt u_cvt (
        .sample_format (sample_format_reg),
        .raw_sample    (in_raw_reg),
        .silent        (in_silent_reg),
        .pcm_sample    (conv_sample),
        .mag           (conv_mag)
    );

    always_comb
    begin
        meter_item.step = advance;
        meter_item.tick = (in_mode_reg == pcm2s16_pkg::MODE_TICK);
        meter_item.channel = in_channel_reg;
        meter_item.mag = conv_mag;
    end

    pcm2s16_meter u_meter (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (channel_count_reg),
        .decay_gain    (decay_gain_reg),
        .item          (meter_item),
        .stats_next    (stats_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= (in_mode_reg == pcm2s16_pkg::MODE_TICK) ? 16'sd0 : conv_sample;
            out_stats_reg <= stats_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.pcm_sample = out_sample_reg;
    assign results.peak_left = out_stats_reg.peak_left;
    assign results.peak_right = out_stats_reg.peak_right;
    assign results.frame_count = out_stats_reg.frame_count;

endmodule
`default_nettype wire

>>> src/pcm2s16_cvt.sv
`default_nettype none
module pcm2s16_cvt (
    input  wire logic [2:0]  sample_format,
    input  wire logic [31:0] raw_sample,
    input  wire logic        silent,
    output logic signed [15:0] pcm_sample,
    output logic [pcm2s16_pkg::PEAK_W-1:0] mag
);

    logic        f_neg;
    logic [7:0]  f_exp;
    logic [22:0] f_man;
    logic [7:0]  f_shift;
    logic [pcm2s16_pkg::FLOAT_PROD_W-1:0] f_prod;
    logic [pcm2s16_pkg::FLOAT_PROD_W-1:0] f_shifted;
    logic [15:0] f_mag;
    logic [15:0] f_sample;
    logic [15:0] conv;

    assign f_neg = raw_sample[31];
    assign f_exp = raw_sample[30:23];
    assign f_man = raw_sample[22:0];
    assign f_shift = pcm2s16_pkg::EXP_SHIFT_BASE - f_exp;
    assign f_prod = pcm2s16_pkg::FLOAT_PROD_W'({1'b1, f_man})
                  * pcm2s16_pkg::FLOAT_PROD_W'(pcm2s16_pkg::FLOAT_SCALE);
    assign f_shifted = f_prod >> f_shift;

    always_comb
    begin
        if (f_exp == pcm2s16_pkg::EXP_SPECIAL && f_man != 23'd0)
        begin
            f_mag = 16'd0;
        end
        else if (f_exp >= pcm2s16_pkg::EXP_ONE)
        begin
            f_mag = pcm2s16_pkg::FULL_SCALE;
        end
        else if (f_exp == 8'd0 || f_shift >= 8'(pcm2s16_pkg::FLOAT_PROD_W))
        begin
            // denormals and values too small to reach one lsb
            f_mag = 16'd0;
        end
        else
        begin
            f_mag = f_shifted[15:0];
        end
        f_sample = f_neg ? (16'd0 - f_mag) : f_mag;
    end

    always_comb
    begin
        unique case (sample_format)
            pcm2s16_pkg::FMT_S16: conv = raw_sample[15:0];
            pcm2s16_pkg::FMT_S24: conv = raw_sample[23:8];
            pcm2s16_pkg::FMT_S32: conv = raw_sample[31:16];
            pcm2s16_pkg::FMT_F32: conv = f_sample;
            default:              conv = 16'd0;
        endcase
        pcm_sample = silent ? 16'sd0 : $signed(conv);
        // -32768 folds to 0x8000, read unsigned as 32768
        mag = pcm_sample[15] ? (16'd0 - $unsigned(pcm_sample)) : $unsigned(pcm_sample);
    end

endmodule
`default_nettype wire

>>> src/pcm2s16_meter.sv
`default_nettype none
module pcm2s16_meter (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [pcm2s16_pkg::COUNT_W-1:0] channel_count,
    input  wire logic [pcm2s16_pkg::GAIN_W-1:0]  decay_gain,
    input  wire pcm2s16_pkg::meter_in_t          item,
    output pcm2s16_pkg::stats_t                  stats_next
);

    logic [pcm2s16_pkg::PEAK_W-1:0]  peak_left_reg;
    logic [pcm2s16_pkg::PEAK_W-1:0]  peak_right_reg;
    logic [pcm2s16_pkg::FRAME_W-1:0] frames_reg;
    logic [pcm2s16_pkg::COUNT_W-1:0] cnt_eff;
    logic [pcm2s16_pkg::COUNT_W-1:0] chan_ext;
    logic [pcm2s16_pkg::DECAY_PROD_W-1:0] decay_left;
    logic [pcm2s16_pkg::DECAY_PROD_W-1:0] decay_right;
    logic in_frame;

    assign decay_left = pcm2s16_pkg::DECAY_PROD_W'(peak_left_reg)
                      * pcm2s16_pkg::DECAY_PROD_W'(decay_gain);
    assign decay_right = pcm2s16_pkg::DECAY_PROD_W'(peak_right_reg)
                       * pcm2s16_pkg::DECAY_PROD_W'(decay_gain);
    assign chan_ext = pcm2s16_pkg::COUNT_W'(item.channel);

    always_comb
    begin
        priority if (channel_count == '0)
        begin
            cnt_eff = pcm2s16_pkg::COUNT_W'(1);
        end
        else if (channel_count > pcm2s16_pkg::COUNT_W'(pcm2s16_pkg::MAX_CHANNELS))
        begin
            cnt_eff = pcm2s16_pkg::COUNT_W'(pcm2s16_pkg::MAX_CHANNELS);
        end
        else
        begin
            cnt_eff = channel_count;
        end
        in_frame = chan_ext < cnt_eff;

        stats_next.peak_left = peak_left_reg;
        stats_next.peak_right = peak_right_reg;
        stats_next.frame_count = frames_reg;
        if (item.tick)
        begin
            stats_next.peak_left =
                decay_left[pcm2s16_pkg::DECAY_PROD_W-1:pcm2s16_pkg::GAIN_W];
            stats_next.peak_right =
                decay_right[pcm2s16_pkg::DECAY_PROD_W-1:pcm2s16_pkg::GAIN_W];
        end
        else if (in_frame)
        begin
            if (chan_ext == pcm2s16_pkg::COUNT_W'(0) && item.mag > peak_left_reg)
            begin
                stats_next.peak_left = item.mag;
            end
            if (chan_ext == pcm2s16_pkg::COUNT_W'(1) && item.mag > peak_right_reg)
            begin
                stats_next.peak_right = item.mag;
            end
            if (chan_ext == cnt_eff - pcm2s16_pkg::COUNT_W'(1))
            begin
                stats_next.frame_count = frames_reg + pcm2s16_pkg::FRAME_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_left_reg <= '0;
            peak_right_reg <= '0;
            frames_reg <= '0;
        end
        else if (item.step)
        begin
            peak_left_reg <= stats_next.peak_left;
            peak_right_reg <= stats_next.peak_right;
            frames_reg <= stats_next.frame_count;
        end
    end

endmodule
`default_nettype wire
